FILE: sv/lpfr_pkg.sv
// package for the length-prefixed frame receiver
// holds phase, frame class and register index types, event and field codes, layout constants and register defaults
// no dependencies
package lpfr_pkg;

    typedef enum logic [1:0] {
        PH_HDR0 = 2'd0,
        PH_HDR1 = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CLS_IGNORE = 2'd0,
        CLS_RECV   = 2'd1,
        CLS_STATUS = 2'd2
    } frame_class_t;

    typedef enum logic [1:0] {
        REG_MAX_LEN    = 2'd0,
        REG_RECV_OP    = 2'd1,
        REG_STATUS_OP  = 2'd2,
        REG_EVENTS_EN  = 2'd3
    } reg_index_t;

    localparam logic       EV_RECV       = 1'b0;
    localparam logic       EV_STATUS     = 1'b1;

    localparam logic [1:0] FK_ADDR       = 2'd0;
    localparam logic [1:0] FK_STRENGTH   = 2'd1;
    localparam logic [1:0] FK_DATA       = 2'd2;
    localparam logic [1:0] FK_STATUS     = 2'd3;

    localparam int         ADDR_BYTES       = 6;
    localparam int         STRENGTH_POS     = 6;
    localparam int         RECV_MIN_LEN     = 8;
    localparam int         RECV_DATA_OFFSET = 7;
    localparam int         STATUS_MIN_LEN   = 2;

    localparam logic [15:0] MAX_LEN_RESET   = 16'd250;
    localparam logic [7:0]  RECV_OP_RESET   = 8'd1;
    localparam logic [7:0]  STATUS_OP_RESET = 8'd2;
    localparam logic        EVENTS_EN_RESET = 1'b0;

endpackage

FILE: sv/length_prefixed_frame_receiver_unit.sv
// length-prefixed frame receiver, top level
// header parse, resync, frame classification and result register in one module
// depends on lpfr_pkg
//
// usage:
//   bytes from the link enter on in_valid/in_ready with rx_byte, one per transaction.
//   each byte causes at most one result on out_valid/out_ready carrying
//   event_kind, field_kind, byte_value, byte_index and last.
//   configuration registers are written on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. write them only while the block is idle.
// path: an accepted byte passes the input register, then the result register, which
//   holds its result on the outputs.
// throughput: one byte per cycle while no result is held back by out_ready; the parse
//   step between the input register and the result register is combinational.
// stall: while a result waits in the output register and out_ready is low, the
//   input register holds its byte and in_ready drops once it is occupied.
// reset: rst_n clears the pipeline, waits for the first header byte and loads
//   the register defaults (limit 250, opcodes 1 and 2, events disabled).
module length_prefixed_frame_receiver_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   event_kind,
    output logic [1:0]             field_kind,
    output logic [7:0]             byte_value,
    output logic [15:0]            byte_index,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  lpfr_pkg::reg_index_t   cfg_index,
    input  logic [15:0]            cfg_data
);
    import lpfr_pkg::*;

    logic [15:0]  max_len_reg;
    logic [7:0]   recv_op_reg;
    logic [7:0]   status_op_reg;
    logic         events_en_reg;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;

    phase_t       phase_reg, phase_next;
    logic [7:0]   header_low_reg, header_low_next;
    logic [15:0]  payload_len_reg, payload_len_next;
    logic [15:0]  bytes_seen_reg, bytes_seen_next;
    frame_class_t class_reg, class_next;

    logic         out_valid_reg;
    logic         event_kind_reg;
    logic [1:0]   field_kind_reg;
    logic [7:0]   byte_value_reg;
    logic [15:0]  byte_index_reg;
    logic         last_reg;

    logic         advance;
    logic         res_valid;
    logic         res_event;
    logic [1:0]   res_field;
    logic [15:0]  res_index;
    logic         res_last;

    logic [16:0]  seen_plus;
    logic         is_last;
    logic [15:0]  hdr_len;
    logic [15:0]  data_pos;

    assign cfg_ready  = 1'b1;
    assign advance    = !(out_valid_reg && !out_ready);
    assign in_ready   = !in_valid_reg || advance;

    assign seen_plus  = {1'b0, bytes_seen_reg} + 17'd1;
    assign is_last    = (seen_plus == {1'b0, payload_len_reg});
    assign hdr_len    = {in_byte_reg, header_low_reg};
    assign data_pos   = bytes_seen_reg - 16'd1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            recv_op_reg   <= RECV_OP_RESET;
            status_op_reg <= STATUS_OP_RESET;
            events_en_reg <= EVENTS_EN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_LEN:   max_len_reg   <= cfg_data;
                REG_RECV_OP:   recv_op_reg   <= cfg_data[7:0];
                REG_STATUS_OP: status_op_reg <= cfg_data[7:0];
                REG_EVENTS_EN: events_en_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        header_low_next  = header_low_reg;
        payload_len_next = payload_len_reg;
        bytes_seen_next  = bytes_seen_reg;
        class_next       = class_reg;
        unique case (phase_reg)
            PH_DATA:
            begin
                if (bytes_seen_reg == 16'd0)
                begin
                    class_next = CLS_IGNORE;
                    if (events_en_reg)
                    begin
                        if (in_byte_reg == recv_op_reg)
                        begin
                            if (payload_len_reg >= 16'(RECV_MIN_LEN))
                                class_next = CLS_RECV;
                        end
                        else if (in_byte_reg == status_op_reg)
                        begin
                            if (payload_len_reg >= 16'(STATUS_MIN_LEN))
                                class_next = CLS_STATUS;
                        end
                    end
                end
                bytes_seen_next = seen_plus[15:0];
                if (is_last)
                begin
                    phase_next      = PH_HDR0;
                    bytes_seen_next = 16'd0;
                    class_next      = CLS_IGNORE;
                end
            end
            PH_HDR1:
            begin
                if (hdr_len == 16'd0 || hdr_len > max_len_reg)
                begin
                    header_low_next = in_byte_reg;
                end
                else
                begin
                    payload_len_next = hdr_len;
                    bytes_seen_next  = 16'd0;
                    class_next       = CLS_IGNORE;
                    phase_next       = PH_DATA;
                end
            end
            default:
            begin
                header_low_next = in_byte_reg;
                phase_next      = PH_HDR1;
            end
        endcase
    end

    // result for the byte in the input register
    always_comb
    begin
        res_valid = 1'b0;
        res_event = EV_RECV;
        res_field = FK_ADDR;
        res_index = 16'd0;
        res_last  = is_last;
        if (phase_reg == PH_DATA && bytes_seen_reg != 16'd0)
        begin
            priority if (class_reg == CLS_RECV)
            begin
                res_valid = 1'b1;
                priority if (data_pos < 16'(ADDR_BYTES))
                begin
                    res_field = FK_ADDR;
                    res_index = data_pos;
                end
                else if (data_pos == 16'(STRENGTH_POS))
                begin
                    res_field = FK_STRENGTH;
                end
                else
                begin
                    res_field = FK_DATA;
                    res_index = data_pos - 16'(RECV_DATA_OFFSET);
                end
            end
            else if (class_reg == CLS_STATUS && bytes_seen_reg == 16'd1)
            begin
                res_valid = 1'b1;
                res_event = EV_STATUS;
                res_field = FK_STATUS;
                res_last  = 1'b1;
            end
            else
            begin
                res_valid = 1'b0;
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            header_low_reg  <= 8'd0;
            payload_len_reg <= 16'd0;
            bytes_seen_reg  <= 16'd0;
            class_reg       <= CLS_IGNORE;
        end
        else if (in_valid_reg && advance)
        begin
            phase_reg       <= phase_next;
            header_low_reg  <= header_low_next;
            payload_len_reg <= payload_len_next;
            bytes_seen_reg  <= bytes_seen_next;
            class_reg       <= class_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && res_valid)
        begin
            event_kind_reg <= res_event;
            field_kind_reg <= res_field;
            byte_value_reg <= in_byte_reg;
            byte_index_reg <= res_index;
            last_reg       <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign field_kind = field_kind_reg;
    assign byte_value = byte_value_reg;
    assign byte_index = byte_index_reg;
    assign last       = last_reg;

endmodule

FILE: tb/frame_event_scoreboard_pkg.sv
// scoreboard for the length-prefixed frame receiver testbench
// predicts result transactions from accepted bytes and register writes, then checks them
// depends on lpfr_pkg
package frame_event_scoreboard_pkg;
    import lpfr_pkg::*;

    typedef struct packed {
        logic        event_kind;
        logic [1:0]  field_kind;
        logic [7:0]  byte_value;
        logic [15:0] byte_index;
        logic        last;
    } frame_result_t;

    class frame_event_scoreboard;
        logic [15:0]   max_len;
        logic [7:0]    recv_op;
        logic [7:0]    status_op;
        logic          events_en;
        phase_t        phase;
        logic [7:0]    hdr_low;
        logic [15:0]   plen;
        logic [15:0]   seen;
        frame_class_t  cls;
        frame_result_t expected_results[$];
        int            bytes_in;
        int            results_checked;
        int            errors;

        function new();
            max_len         = MAX_LEN_RESET;
            recv_op         = RECV_OP_RESET;
            status_op       = STATUS_OP_RESET;
            events_en       = EVENTS_EN_RESET;
            phase           = PH_HDR0;
            hdr_low         = 8'd0;
            plen            = 16'd0;
            seen            = 16'd0;
            cls             = CLS_IGNORE;
            bytes_in        = 0;
            results_checked = 0;
            errors          = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] v);
            case (idx)
                REG_MAX_LEN:   max_len   = v;
                REG_RECV_OP:   recv_op   = v[7:0];
                REG_STATUS_OP: status_op = v[7:0];
                REG_EVENTS_EN: events_en = v[0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            logic [15:0]   k;
            logic [15:0]   d;
            logic [15:0]   hdr;
            logic          is_last;
            bit            emit;
            frame_result_t r;
            bytes_in++;
            emit = 1'b0;
            r = '0;
            case (phase)
                PH_DATA:
                begin
                    k = seen;
                    is_last = ((k + 16'd1) == plen);
                    if (k == 16'd0)
                    begin
                        // opcodes and enable are taken on the command byte only
                        cls = CLS_IGNORE;
                        if (events_en)
                        begin
                            if (b == recv_op)
                            begin
                                if (plen >= RECV_MIN_LEN)
                                    cls = CLS_RECV;
                            end
                            else if (b == status_op)
                            begin
                                if (plen >= STATUS_MIN_LEN)
                                    cls = CLS_STATUS;
                            end
                        end
                    end
                    else if (cls == CLS_RECV)
                    begin
                        d = k - 16'd1;
                        r.event_kind = EV_RECV;
                        r.byte_value = b;
                        r.last       = is_last;
                        if (d < ADDR_BYTES)
                        begin
                            r.field_kind = FK_ADDR;
                            r.byte_index = d;
                        end
                        else if (d == STRENGTH_POS)
                        begin
                            r.field_kind = FK_STRENGTH;
                            r.byte_index = 16'd0;
                        end
                        else
                        begin
                            r.field_kind = FK_DATA;
                            r.byte_index = d - 16'(RECV_DATA_OFFSET);
                        end
                        emit = 1'b1;
                    end
                    else if (cls == CLS_STATUS && k == 16'd1)
                    begin
                        r.event_kind = EV_STATUS;
                        r.field_kind = FK_STATUS;
                        r.byte_value = b;
                        r.byte_index = 16'd0;
                        r.last       = 1'b1;
                        emit = 1'b1;
                    end
                    seen = k + 16'd1;
                    if (is_last)
                    begin
                        phase = PH_HDR0;
                        seen  = 16'd0;
                        cls   = CLS_IGNORE;
                    end
                end
                PH_HDR1:
                begin
                    hdr = {b, hdr_low};
                    // bad length: high byte slides down as the next low byte
                    if (hdr == 16'd0 || hdr > max_len)
                        hdr_low = b;
                    else
                    begin
                        plen  = hdr;
                        seen  = 16'd0;
                        cls   = CLS_IGNORE;
                        phase = PH_DATA;
                    end
                end
                default:
                begin
                    hdr_low = b;
                    phase   = PH_HDR1;
                end
            endcase
            if (emit)
                expected_results.push_back(r);
        endfunction

        function void check_result(logic ev, logic [1:0] fk, logic [7:0] val,
                                   logic [15:0] idx, logic lst);
            frame_result_t e;
            results_checked++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %0d field %0d value %02h index %0d last %0d",
                             ev, fk, val, idx, lst);
                return;
            end
            e = expected_results.pop_front();
            if (e.event_kind !== ev || e.field_kind !== fk || e.byte_value !== val ||
                e.byte_index !== idx || e.last !== lst)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %0d expected: kind %0d field %0d value %02h index %0d last %0d",
                             results_checked, e.event_kind, e.field_kind, e.byte_value,
                             e.byte_index, e.last);
                    $display("result %0d actual:   kind %0d field %0d value %02h index %0d last %0d",
                             results_checked, ev, fk, val, idx, lst);
                end
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_length_prefixed_frame_receiver_unit.sv
// testbench top for length_prefixed_frame_receiver_unit
// drives directed and random link bytes and register settings, checks every result transaction
// depends on lpfr_pkg, frame_event_scoreboard_pkg and the block's rtl
module tb_length_prefixed_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfr_pkg::*;
    import frame_event_scoreboard_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        event_kind;
    logic [1:0]  field_kind;
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    reg_index_t  cfg_index;
    logic [15:0] cfg_data;

    frame_event_scoreboard sb = new();
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int frames   = 0;
    int settings = 0;

    length_prefixed_frame_receiver_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .field_kind (field_kind),
        .byte_value (byte_value),
        .byte_index (byte_index),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(event_kind, field_kind, byte_value, byte_index, last);
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("length_prefixed_frame_receiver_unit: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic program_regs(input logic [15:0] lim, input logic [7:0] rop,
                                input logic [7:0] sop, input logic en);
        reg_index_t  idx [4];
        logic [15:0] val [4];
        idx = '{REG_MAX_LEN, REG_RECV_OP, REG_STATUS_OP, REG_EVENTS_EN};
        val = '{lim, {8'd0, rop}, {8'd0, sop}, {15'd0, en}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // steer the parser back to a frame boundary
    task automatic realign();
        while (sb.phase != PH_HDR0)
        begin
            if (sb.phase == PH_DATA)
                send_byte(8'($urandom));
            else if (sb.hdr_low != 8'd0 && 16'(sb.hdr_low) <= sb.max_len)
                send_byte(8'h00);
            else
                send_byte(8'h01);
        end
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd);
        realign();
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (sb.phase == PH_DATA)
        begin
            frames++;
            send_byte(cmd);
            while (sb.phase == PH_DATA) send_byte(8'($urandom));
        end
    endtask

    task automatic run_traffic(input int n_bytes, input bit noisy, input int len_cap);
        int         start;
        int         pick;
        int         cap;
        int         len;
        logic [7:0] cmd;
        start = sb.bytes_in;
        cap = (len_cap < int'(sb.max_len)) ? len_cap : int'(sb.max_len);
        while (sb.bytes_in - start < n_bytes)
        begin
            pick = $urandom_range(99);
            if (noisy && pick < 10)
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            else if (noisy && pick < 20)
            begin
                // rejected header: zero length, or just or well above the limit
                if ($urandom_range(1))
                    len = 0;
                else
                    len = int'(sb.max_len) + ($urandom_range(1) ? 1 : $urandom_range(2, 300));
                send_frame(len[15:0], 8'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    len = cap;
                else if (pick < 25)
                    len = $urandom_range(6, 9);
                else
                    len = $urandom_range(1, (cap < 24) ? cap : 24);
                if (len > cap)
                    len = cap;
                pick = $urandom_range(99);
                cmd = (pick < 45) ? sb.recv_op : (pick < 75) ? sb.status_op : 8'($urandom);
                send_frame(len[15:0], cmd);
            end
        end
    endtask

    initial
    begin
        logic [7:0] directed [23];
        directed = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'hFF,
                     8'h08, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80,
                     8'h01, 8'h00, 8'h02,
                     8'h02, 8'h00, 8'h55, 8'h7F};
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MAX_LEN;
        cfg_data  <= 16'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_regs(MAX_LEN_RESET, RECV_OP_RESET, STATUS_OP_RESET, 1'b1);
        foreach (directed[i]) send_byte(directed[i]);
        run_traffic(150, 1'b1, 250);
        settle();

        idle_on = 1'b0;
        program_regs(16'hFFFF, 8'hFF, 8'h00, 1'b1);
        send_frame(16'd600, 8'hFF);
        run_traffic(150, 1'b0, 40);
        settle();
        idle_on = 1'b1;

        program_regs(16'd20, 8'd7, 8'd7, 1'b1);
        run_traffic(150, 1'b1, 20);
        settle();

        program_regs(MAX_LEN_RESET, RECV_OP_RESET, STATUS_OP_RESET, 1'b0);
        run_traffic(80, 1'b1, 250);
        settle();

        program_regs(16'd1, RECV_OP_RESET, STATUS_OP_RESET, 1'b1);
        run_traffic(30, 1'b1, 1);
        settle();

        program_regs(16'd0, RECV_OP_RESET, STATUS_OP_RESET, 1'b1);
        repeat (20) send_byte(8'($urandom));
        settle();

        program_regs(16'($urandom_range(8, 255)), 8'($urandom), 8'($urandom), 1'b1);
        hold_req = 1'b1;
        run_traffic(200, 1'b1, 255);
        settle();

        program_regs(16'd255, 8'h00, 8'hFF, 1'b1);
        run_traffic(60, 1'b1, 255);
        settle();

        $display("run covered %0d bytes in %0d frames, %0d results checked, %0d register settings",
                 sb.bytes_in, frames, sb.results_checked, settings);
        $display("incl. resync, short/status-only frames, equal opcodes, limits 0/1/65535, hold-off");
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("length_prefixed_frame_receiver_unit: match");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", sb.errors,
                     sb.expected_results.size());
            $display("length_prefixed_frame_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule
